### rtl/cra_pkg.sv
`default_nettype none
package cra_pkg;

	// Array geometry
	localparam int CRYSTALS_PER_CLOVER = 4;
	localparam int CLOVER_COUNT        = 2;
	localparam int CHANNELS            = CLOVER_COUNT * CRYSTALS_PER_CLOVER;
	localparam int KINDS               = 9;
	localparam int TABLE_DEPTH         = CHANNELS * KINDS;
	localparam int ADDR_W              = $clog2(TABLE_DEPTH);
	localparam int CL_W                = (CLOVER_COUNT > 1) ? $clog2(CLOVER_COUNT) : 1;
	localparam int CR_W                = 2;
	localparam int TS_W                = 48;
	localparam int COUNT_BITS          = 16;
	localparam int ENERGY_W            = 26;
	localparam int WINDOW_W            = 16;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX   = {ENERGY_W{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

	// Item functions
	localparam logic [1:0] FUNC_HIT   = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;

	// Coefficient slots within one channel's row
	localparam logic [3:0] KIND_OLD_OFF   = 4'd0;
	localparam logic [3:0] KIND_LOW_OFF   = 4'd3;
	localparam logic [3:0] KIND_HIGH_OFF  = 4'd6;

	// Result kinds
	localparam logic RES_HIT   = 1'b0;
	localparam logic RES_EVENT = 1'b1;

	typedef struct packed {
		logic [1:0]         func;
		logic [2:0]         detector_channel;
		logic [TS_W-1:0]    hit_timestamp;
		logic [19:0]        hit_energy;
		logic [3:0]         coefficient_kind;
		logic signed [63:0] coefficient_value;
	} in_t;

	typedef struct packed {
		logic                  result_kind;
		logic                  clover_number;
		logic [1:0]            crystal;
		logic [ENERGY_W-1:0]   energy_out;
		logic [TS_W-1:0]       time_out;
		logic [TS_W-1:0]       event_span;
		logic [15:0]           count_crystal_a;
		logic [15:0]           count_crystal_b;
		logic [15:0]           count_crystal_c;
		logic [15:0]           count_crystal_d;
		logic                  last_of_run;
	} out_t;

	typedef enum logic [1:0] {
		SH_32,
		SH_48,
		SH_56
	} mul_shift_t;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		mul_shift_t         shift;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] p;
	} mul_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_FETCH3,
		ST_ADC_WAIT,
		ST_SEL0,
		ST_SEL1,
		ST_SEL2,
		ST_SEL3,
		ST_T1_WAIT,
		ST_SQ_WAIT,
		ST_T2_WAIT,
		ST_SUM,
		ST_EMIT_HIT,
		ST_EMIT_EV,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

endpackage
`default_nettype wire

### rtl/cra_mulsh.sv
`default_nettype none
// Signed 64x64 multiply, floor shift right and saturate to 64 bits.
// One 32x32 multiplier is reused over four partial products.
module cra_mulsh import cra_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);

	logic               busy_q;
	logic [2:0]         step_q;
	logic               done_q;
	logic [63:0]        ua_q;
	logic [63:0]        ub_q;
	logic               neg_q;
	mul_shift_t         sh_q;
	logic [63:0]        prod_s1;
	logic [1:0]         off_s1;
	logic [127:0]       acc_q;
	logic signed [63:0] p_q;

	logic [31:0]  a_part;
	logic [31:0]  b_part;
	logic [127:0] addend;
	logic [63:0]  sat_val;

	// Partial product operands: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
	assign a_part = step_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign b_part = step_q[0] ? ub_q[63:32] : ub_q[31:0];

	always_comb begin
		unique case (off_s1)
			2'd1:    addend = {32'd0, prod_s1, 32'd0};
			2'd2:    addend = {prod_s1, 64'd0};
			default: addend = {64'd0, prod_s1};
		endcase
	end

	// Saturate the shifted 128-bit product
	always_comb begin
		unique case (sh_q)
			SH_32: sat_val = ((&acc_q[127:95]) || !(|acc_q[127:95])) ? acc_q[95:32]
				: (acc_q[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
			SH_48: sat_val = ((&acc_q[127:111]) || !(|acc_q[127:111])) ? acc_q[111:48]
				: (acc_q[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
			default: sat_val = ((&acc_q[127:119]) || !(|acc_q[127:119])) ? acc_q[119:56]
				: (acc_q[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
		endcase
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					step_q <= 3'd0;
				end
			end else begin
				if (step_q == 3'd6) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				ua_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
				ub_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
				neg_q <= req.a[63] ^ req.b[63];
				sh_q  <= req.shift;
				acc_q <= '0;
			end
		end else begin
			if (step_q < 3'd4) begin
				prod_s1 <= 64'(a_part) * 64'(b_part);
				off_s1  <= 2'(step_q[1]) + 2'(step_q[0]);
			end
			if (step_q >= 3'd1 && step_q <= 3'd4)
				acc_q <= acc_q + addend;
			if (step_q == 3'd5 && neg_q)
				acc_q <= 128'd0 - acc_q;
			if (step_q == 3'd6)
				p_q <= sat_val;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule
`default_nettype wire

### rtl/clover_recalibrate_and_addback.sv
// Clover recalibration and addback.
// Input channel in_valid/in_stall/in_data carries hits, coefficient writes and
// flushes; output channel out_valid/out_stall/out_data carries recalibrated
// hits and closed addback events. A transaction moves at an edge where valid
// is high and stall is low. cfg_we/cfg_data writes the coincidence window.
// One item is processed at a time; in_stall stays high until its results are
// all loaded into the output register. A hit makes six coefficient reads,
// four 64x64 multiplies on the shared 32x32 multiplier, the sum and the
// event update, and it also emits an event result when it closes an event.
// Results leave through a single output register; while the receiver stalls
// it holds, and the sequencer waits before loading the next result.
// Reset clears all events, the counts and the window (to 1000); the
// coefficient memory is undefined until written.
`default_nettype none
module clover_recalibrate_and_addback import cra_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_t                 in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_t                     out_data,
	input  wire logic                cfg_we,
	input  wire logic [WINDOW_W-1:0] cfg_data
);

	// Coefficient memory
	logic [63:0] mem [TABLE_DEPTH];
	logic [63:0] rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic mem_we;
	logic [ADDR_W-1:0] waddr;

	state_t state_q, state_d;

	in_t                 item_q;
	logic [WINDOW_W-1:0] window_q;
	logic [ADDR_W-1:0]   row_q;
	logic [ADDR_W-1:0]   set_q;
	logic signed [63:0]  diff_q, recip_q, sep_q, adc_q;
	logic signed [63:0]  off_q, gain_q, quad_q, t1_q, t2_q;
	logic [ENERGY_W-1:0] e_q;
	logic [CL_W:0]       fl_q;

	// Event state
	logic                  open_q  [CLOVER_COUNT];
	logic [TS_W-1:0]       start_q [CLOVER_COUNT];
	logic [TS_W-1:0]       prev_q  [CLOVER_COUNT];
	logic [1:0]            first_q [CLOVER_COUNT];
	logic [ENERGY_W-1:0]   sum_q   [CLOVER_COUNT];
	logic [COUNT_BITS-1:0] cnt_q   [CLOVER_COUNT][CRYSTALS_PER_CLOVER];

	logic   out_valid_q;
	out_t   out_q;
	logic   slot_free;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	logic [CL_W-1:0] cl;
	logic [1:0]      cr;
	logic            ch_ok;
	logic            close_hit;
	logic            more_open;
	logic [CL_W-1:0] fl_idx;
	logic            fl_done;
	logic            low_set;
	logic signed [63:0] s1, s2;
	logic [ENERGY_W-1:0] e_clamp;

	cra_mulsh u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		return r;
	endfunction

	// Item decode
	assign cl      = CL_W'(item_q.detector_channel / 3'(CRYSTALS_PER_CLOVER));
	assign cr      = 2'(item_q.detector_channel % 3'(CRYSTALS_PER_CLOVER));
	assign ch_ok   = {1'b0, item_q.detector_channel} < 4'(CHANNELS);
	assign fl_idx  = CL_W'(fl_q);
	assign fl_done = fl_q >= (CL_W+1)'(CLOVER_COUNT);
	assign slot_free = !out_valid_q || !out_stall;

	assign close_hit = open_q[cl] && (item_q.hit_timestamp >= start_q[cl])
		&& ((item_q.hit_timestamp - start_q[cl]) > TS_W'(window_q));

	assign low_set = (adc_q >>> 32) < sep_q;

	// Any open clover above the one being flushed
	always_comb begin
		more_open = 1'b0;
		for (int i = 0; i < CLOVER_COUNT; i++)
			if (i > int'(fl_q) && open_q[i]) more_open = 1'b1;
	end

	// Final energy
	assign s1 = sadd(off_q >>> 24, t1_q);
	assign s2 = sadd(s1, t2_q);
	always_comb begin
		if (s2[63])
			e_clamp = '0;
		else if (|s2[62:52])
			e_clamp = ENERGY_MAX;
		else
			e_clamp = s2[51:26];
	end

	// Next state and control
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		raddr    = row_q;
		mem_we   = 1'b0;
		waddr    = ADDR_W'(7'(item_q.detector_channel) * 7'(KINDS)
			+ 7'(item_q.coefficient_kind));
		mreq.start = 1'b0;
		mreq.a     = adc_q;
		mreq.b     = adc_q;
		mreq.shift = SH_32;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				priority if (item_q.func == FUNC_WRITE) begin
					mem_we  = ch_ok && (item_q.coefficient_kind < 4'(KINDS));
					state_d = ST_IDLE;
				end else if (item_q.func == FUNC_FLUSH) begin
					state_d = ST_FLUSH;
				end else if (item_q.func == FUNC_HIT && ch_ok) begin
					state_d = ST_FETCH0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FETCH0: begin
				raddr   = row_q;
				state_d = ST_FETCH1;
			end
			ST_FETCH1: begin
				raddr   = row_q + ADDR_W'(1);
				state_d = ST_FETCH2;
			end
			ST_FETCH2: begin
				raddr   = row_q + ADDR_W'(2);
				state_d = ST_FETCH3;
			end
			ST_FETCH3: begin
				mreq.start = 1'b1;
				mreq.a     = diff_q;
				mreq.b     = recip_q;
				mreq.shift = SH_48;
				state_d    = ST_ADC_WAIT;
			end
			ST_ADC_WAIT: begin
				if (mrsp.done) state_d = ST_SEL0;
			end
			ST_SEL0: begin
				raddr   = row_q + (low_set ? ADDR_W'(KIND_LOW_OFF) : ADDR_W'(KIND_HIGH_OFF));
				state_d = ST_SEL1;
			end
			ST_SEL1: begin
				raddr   = set_q + ADDR_W'(1);
				state_d = ST_SEL2;
			end
			ST_SEL2: begin
				raddr   = set_q + ADDR_W'(2);
				state_d = ST_SEL3;
			end
			ST_SEL3: begin
				mreq.start = 1'b1;
				mreq.a     = gain_q;
				mreq.b     = adc_q;
				mreq.shift = SH_56;
				state_d    = ST_T1_WAIT;
			end
			ST_T1_WAIT: begin
				// adc squared follows at once
				mreq.start = mrsp.done;
				if (mrsp.done) state_d = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				mreq.start = mrsp.done;
				mreq.a     = quad_q;
				mreq.b     = mrsp.p;
				mreq.shift = SH_56;
				if (mrsp.done) state_d = ST_T2_WAIT;
			end
			ST_T2_WAIT: begin
				if (mrsp.done) state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_EMIT_HIT;
			end
			ST_EMIT_HIT: begin
				if (slot_free) state_d = close_hit ? ST_EMIT_EV : ST_UPDATE;
			end
			ST_EMIT_EV: begin
				if (slot_free) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				priority if (fl_done)
					state_d = ST_IDLE;
				else if (!open_q[fl_idx] || slot_free)
					state_d = ST_FLUSH;
				else
					state_d = ST_FLUSH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Memory ports
	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= item_q.coefficient_value;
		rdata_q <= mem[raddr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     window_q <= WINDOW_RESET;
		else if (cfg_we) window_q <= cfg_data;
	end

	// Item and arithmetic registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= in_data;
			end
			ST_DECODE: begin
				row_q <= ADDR_W'(7'(item_q.detector_channel) * 7'(KINDS));
			end
			ST_FETCH1: begin
				diff_q <= $signed({18'd0, item_q.hit_energy, 26'd0})
					- ($signed(rdata_q) >>> 24);
			end
			ST_FETCH2: recip_q <= rdata_q;
			ST_FETCH3: sep_q   <= rdata_q;
			ST_ADC_WAIT: begin
				if (mrsp.done) adc_q <= mrsp.p;
			end
			ST_SEL0: begin
				set_q <= row_q + (low_set ? ADDR_W'(KIND_LOW_OFF) : ADDR_W'(KIND_HIGH_OFF));
			end
			ST_SEL1: off_q  <= rdata_q;
			ST_SEL2: gain_q <= rdata_q;
			ST_SEL3: quad_q <= rdata_q;
			ST_T1_WAIT: begin
				if (mrsp.done) t1_q <= mrsp.p;
			end
			ST_T2_WAIT: begin
				if (mrsp.done) t2_q <= mrsp.p;
			end
			ST_SUM: e_q <= e_clamp;
			default: ;
		endcase
	end

	// Flush walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= '0;
		end else if (state_q == ST_DECODE) begin
			fl_q <= '0;
		end else if (state_q == ST_FLUSH && !fl_done) begin
			if (!open_q[fl_idx] || slot_free) fl_q <= fl_q + (CL_W+1)'(1);
		end
	end

	// Event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLOVER_COUNT; i++) begin
				open_q[i]  <= 1'b0;
				start_q[i] <= '0;
				prev_q[i]  <= '0;
				first_q[i] <= '0;
				sum_q[i]   <= '0;
				for (int j = 0; j < CRYSTALS_PER_CLOVER; j++) cnt_q[i][j] <= '0;
			end
		end else begin
			if (state_q == ST_EMIT_EV && slot_free)
				open_q[cl] <= 1'b0;
			if (state_q == ST_FLUSH && !fl_done && open_q[fl_idx] && slot_free)
				open_q[fl_idx] <= 1'b0;
			if (state_q == ST_UPDATE) begin
				open_q[cl] <= 1'b1;
				prev_q[cl] <= item_q.hit_timestamp;
				if (!open_q[cl]) begin
					start_q[cl] <= item_q.hit_timestamp;
					first_q[cl] <= cr;
					sum_q[cl]   <= e_q;
					for (int j = 0; j < CRYSTALS_PER_CLOVER; j++)
						cnt_q[cl][j] <= (j == int'(cr)) ? COUNT_BITS'(1) : '0;
				end else begin
					sum_q[cl] <= ({1'b0, sum_q[cl]} + {1'b0, e_q} > {1'b0, ENERGY_MAX})
						? ENERGY_MAX : sum_q[cl] + e_q;
					if (cnt_q[cl][cr] != COUNT_MAX)
						cnt_q[cl][cr] <= cnt_q[cl][cr] + COUNT_BITS'(1);
				end
			end
		end
	end

	// Event result for a clover
	function automatic out_t event_result(input logic [CL_W-1:0] c, input logic last,
		input logic [TS_W-1:0] st, input logic [TS_W-1:0] pv, input logic [1:0] fc,
		input logic [ENERGY_W-1:0] sm, input logic [4*COUNT_BITS-1:0] cn);
		out_t r;
		r.result_kind     = RES_EVENT;
		r.clover_number   = 1'(c);
		r.crystal         = fc;
		r.energy_out      = sm;
		r.time_out        = st;
		r.event_span      = (pv >= st) ? pv - st : '0;
		r.count_crystal_a = 16'(cn[COUNT_BITS-1:0]);
		r.count_crystal_b = 16'(cn[2*COUNT_BITS-1:COUNT_BITS]);
		r.count_crystal_c = 16'(cn[3*COUNT_BITS-1:2*COUNT_BITS]);
		r.count_crystal_d = 16'(cn[4*COUNT_BITS-1:3*COUNT_BITS]);
		r.last_of_run     = last;
		return r;
	endfunction

	logic [4*COUNT_BITS-1:0] cn_hit, cn_fl;
	always_comb begin
		cn_hit = '0;
		cn_fl  = '0;
		for (int j = 0; j < CRYSTALS_PER_CLOVER && j < 4; j++) begin
			cn_hit[j*COUNT_BITS +: COUNT_BITS] = cnt_q[cl][j];
			cn_fl[j*COUNT_BITS +: COUNT_BITS]  = cnt_q[fl_idx][j];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (slot_free && (state_q == ST_EMIT_HIT || state_q == ST_EMIT_EV
				|| (state_q == ST_FLUSH && !fl_done && open_q[fl_idx])))
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == ST_EMIT_HIT) begin
				out_q.result_kind     <= RES_HIT;
				out_q.clover_number   <= 1'(cl);
				out_q.crystal         <= cr;
				out_q.energy_out      <= e_q;
				out_q.time_out        <= item_q.hit_timestamp;
				out_q.event_span      <= '0;
				out_q.count_crystal_a <= '0;
				out_q.count_crystal_b <= '0;
				out_q.count_crystal_c <= '0;
				out_q.count_crystal_d <= '0;
				out_q.last_of_run     <= !close_hit;
			end else if (state_q == ST_EMIT_EV) begin
				out_q <= event_result(cl, 1'b1, start_q[cl], prev_q[cl], first_q[cl],
					sum_q[cl], cn_hit);
			end else if (state_q == ST_FLUSH && !fl_done && open_q[fl_idx]) begin
				out_q <= event_result(fl_idx, !more_open, start_q[fl_idx], prev_q[fl_idx],
					first_q[fl_idx], sum_q[fl_idx], cn_fl);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### rtl/cra_check.sv
`default_nettype none
module cra_check import cra_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire out_t out_data
);

	// A held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	// One item at a time: an accepted transaction makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted at once");

	// Single hits carry no event span or counts
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == RES_HIT |->
		out_data.event_span == '0 && out_data.count_crystal_a == '0
		&& out_data.count_crystal_b == '0 && out_data.count_crystal_c == '0
		&& out_data.count_crystal_d == '0)
		else $error("hit result with event fields");

endmodule

bind clover_recalibrate_and_addback cra_check u_cra_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
